[hdl/dcf_pkg.sv]
// Shared constants for the dual-channel low-pass FIR block.
// Holds the Q0.17 coefficient table and its lookup function; no dependencies.
package dcf_pkg;

    localparam int COEF_W    = 18;
    localparam int FRAC_BITS = 17;
    localparam int ROM_TAPS  = 51;

    localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_TAPS] = '{
        18'sd0,    18'sd22,   18'sd50,   18'sd93,   18'sd155,
        18'sd244,  18'sd364,  18'sd522,  18'sd720,  18'sd962,
        18'sd1247, 18'sd1573, 18'sd1939, 18'sd2338, 18'sd2763,
        18'sd3206, 18'sd3656, 18'sd4102, 18'sd4532, 18'sd4935,
        18'sd5299, 18'sd5613, 18'sd5868, 18'sd6056, 18'sd6171,
        18'sd6210, 18'sd6171, 18'sd6056, 18'sd5868, 18'sd5613,
        18'sd5299, 18'sd4935, 18'sd4532, 18'sd4102, 18'sd3656,
        18'sd3206, 18'sd2763, 18'sd2338, 18'sd1939, 18'sd1573,
        18'sd1247, 18'sd962,  18'sd720,  18'sd522,  18'sd364,
        18'sd244,  18'sd155,  18'sd93,   18'sd50,   18'sd22,
        18'sd0
    };

    // Taps beyond the end of the table carry a zero coefficient.
    function automatic logic signed [COEF_W-1:0] coef_at(input int idx);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (idx >= 0 && idx < ROM_TAPS)
        begin
            c = COEF_ROM[idx];
        end
        return c;
    endfunction

endpackage

[hdl/dcf_tap_cell.sv]
// One tap of the transposed-form FIR chain: multiply, add and hold a partial sum.
// Depends on dcf_pkg for the coefficient width.
module dcf_tap_cell
    import dcf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W = 40,
    parameter logic signed [COEF_W-1:0] COEF = '0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [ACC_W-1:0]       partial_in,
    output logic signed [ACC_W-1:0]       partial_out
);

    localparam int PROD_W = SAMPLE_BITS + COEF_W;

    logic signed [PROD_W-1:0] product;
    logic signed [ACC_W-1:0]  partial_reg;
    logic signed [ACC_W-1:0]  partial_next;

    assign product      = PROD_W'(sample) * PROD_W'(COEF);
    assign partial_next = {{(ACC_W-PROD_W){product[PROD_W-1]}}, product} + partial_in;
    assign partial_out  = partial_reg;

    // A cleared partial sum is the same as a history of zero samples.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
        end
        else if (enable)
        begin
            partial_reg <= partial_next;
        end
    end

endmodule

[hdl/dcf_out_stage.sv]
// Output register of the filter: rounds, saturates and holds both channel results.
// Depends on dcf_pkg for the fraction width.
module dcf_out_stage
    import dcf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W = 40
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sum_valid,
    input  logic signed [ACC_W-1:0]       red_sum,
    input  logic signed [ACC_W-1:0]       infrared_sum,
    input  logic                          out_stall,
    output logic                          take,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] red_filtered,
    output logic signed [SAMPLE_BITS-1:0] infrared_filtered
);

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF_LSB =
        {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] shifted;
        logic signed [SAMPLE_BITS-1:0] y;
        shifted = (acc + HALF_LSB) >>> FRAC_BITS;
        if (shifted > SAT_MAX)
        begin
            y = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            y = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            y = shifted[SAMPLE_BITS-1:0];
        end
        return y;
    endfunction

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] red_filtered_reg;
    logic signed [SAMPLE_BITS-1:0] infrared_filtered_reg;

    assign take           = sum_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = take || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            red_filtered_reg      <= round_sat(red_sum);
            infrared_filtered_reg <= round_sat(infrared_sum);
        end
    end

    assign out_valid         = out_valid_reg;
    assign red_filtered      = red_filtered_reg;
    assign infrared_filtered = infrared_filtered_reg;

endmodule

[hdl/dual_channel_fir_51tap_top.sv]
// Top level of the dual-channel symmetric low-pass FIR filter.
// Depends on dcf_pkg, dcf_tap_cell and dcf_out_stage.
//
// Usage
// Each input transaction carries one red and one infrared sample; each output
// transaction carries the two filtered samples that belong to it, in order.
// Both channels use valid and stall: a transaction completes at a rising edge
// where valid is high and stall is low.
// Each channel runs through its own transposed-form chain of TAP_COUNT cells.
// A cell multiplies the new sample by its fixed coefficient and adds the partial
// sum handed up from its neighbour, so the full sum is registered in the first
// cell at the edge that takes the sample. The output stage then rounds to
// nearest (ties upward) and saturates to SAMPLE_BITS.
// An accepted input is summed into the chain head register and then rounded into
// the output register. One transaction is taken every cycle while the receiver
// does not stall; the rate is set by the single multiply and add per cell.
// Reset clears every partial sum, which equals an all-zero sample history, and
// empties the output register.
// When the receiver stalls, the result is held in the output register and one
// further sum waits in the chain head; input is stalled only once both are full.
module dual_channel_fir_51tap_top
    import dcf_pkg::*;
#(
    parameter int TAP_COUNT = 51,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] red_sample,
    input  logic signed [SAMPLE_BITS-1:0] infrared_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] red_filtered,
    output logic signed [SAMPLE_BITS-1:0] infrared_filtered
);

    // Full-precision accumulator: product width plus growth over all taps.
    localparam int ACC_W = SAMPLE_BITS + COEF_W + $clog2(TAP_COUNT);

    logic in_fire;
    logic take;
    logic sum_valid_reg;
    logic sum_valid_next;

    // Partial sums travel from the far end of each chain toward element zero.
    logic signed [ACC_W-1:0] red_partial [TAP_COUNT+1];
    logic signed [ACC_W-1:0] ir_partial  [TAP_COUNT+1];

    // The chain head can take a new sum whenever its current one leaves.
    assign in_stall = sum_valid_reg && !take;
    assign in_fire  = in_valid && !in_stall;

    assign sum_valid_next = in_fire || (sum_valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
        end
    end

    assign red_partial[TAP_COUNT] = '0;
    assign ir_partial[TAP_COUNT]  = '0;

    // Cell k weights the newest sample with coefficient k; every cell advances
    // only on an accepted transaction, so the chain keeps the sample history.
    for (genvar k = 0; k < TAP_COUNT; k++)
    begin : g_tap
        dcf_tap_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .ACC_W       (ACC_W),
            .COEF        (coef_at(k))
        ) u_red_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .enable      (in_fire),
            .sample      (red_sample),
            .partial_in  (red_partial[k+1]),
            .partial_out (red_partial[k])
        );

        dcf_tap_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .ACC_W       (ACC_W),
            .COEF        (coef_at(k))
        ) u_ir_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .enable      (in_fire),
            .sample      (infrared_sample),
            .partial_in  (ir_partial[k+1]),
            .partial_out (ir_partial[k])
        );
    end

    dcf_out_stage #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_out_stage (
        .clk               (clk),
        .rst_n             (rst_n),
        .sum_valid         (sum_valid_reg),
        .red_sum           (red_partial[0]),
        .infrared_sum      (ir_partial[0]),
        .out_stall         (out_stall),
        .take              (take),
        .out_valid         (out_valid),
        .red_filtered      (red_filtered),
        .infrared_filtered (infrared_filtered)
    );

endmodule

[hdl/dcf_checker.sv]
// Port-level checks for the dual-channel FIR top level, with the bind that attaches them.
// Depends on dual_channel_fir_51tap_top for the bind target.
module dcf_checker
#(
    parameter int SAMPLE_BITS = 16
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] red_filtered,
    input logic signed [SAMPLE_BITS-1:0] infrared_filtered
);

    // A stalled result must stay put until it is taken.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_filtered)
                                  && $stable(infrared_filtered))
        else $error("stalled output transaction changed");

    // With the output register free or draining, the input side never stalls.
    a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) |-> !in_stall)
        else $error("input stalled while output side could move");

    // An accepted sample passes the chain head into the output register unless held back.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("accepted transaction did not reach the output");

endmodule

bind dual_channel_fir_51tap_top dcf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dcf_checker (.*);

[verif/dual_channel_fir_51tap_top_tb.sv]
// Self-checking testbench for the dual-channel 51-tap low-pass FIR block.
// Depends only on dual_channel_fir_51tap_top and its package; it carries its own
// coefficient table and delay lines to predict every filtered pair.
`timescale 1ns / 100ps

module dual_channel_fir_51tap_top_tb;

    // Block configuration under test; the block is built with the same values.
    localparam int TAP_COUNT   = 51;
    localparam int SAMPLE_BITS = 16;
    localparam int HIST_DEPTH  = TAP_COUNT - 1;
    localparam int FRAC_BITS   = 17;

    localparam longint ROUND_HALF = longint'(1) <<< (FRAC_BITS - 1);
    localparam longint SAT_MAX    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_MIN    = -SAT_MAX - 1;

    localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = 16'sh8000;

    localparam int RANDOM_ITEMS    = 540;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;
    localparam int DIRECTED_COUNT  = 20;

    // Low-pass coefficients in Q0.17, the rounded form of the symmetric design.
    localparam int LOWPASS_COEF [TAP_COUNT] = '{
        0,    22,   50,   93,   155,  244,  364,  522,  720,  962,
        1247, 1573, 1939, 2338, 2763, 3206, 3656, 4102, 4532, 4935,
        5299, 5613, 5868, 6056, 6171, 6210, 6171, 6056, 5868, 5613,
        5299, 4935, 4532, 4102, 3656, 3206, 2763, 2338, 1939, 1573,
        1247, 962,  720,  522,  364,  244,  155,  93,   50,   22,
        0
    };

    // Corner pairs: full-scale steps of either sign, single-LSB values,
    // alternating bit patterns and a zero tail to let the history move on.
    localparam logic signed [SAMPLE_BITS-1:0] CORNER_RED [DIRECTED_COUNT] = '{
        16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
        16'sh0000, 16'shffff, 16'sh0001, 16'shffff, 16'sh5555,
        16'shaaaa, 16'sh7fff, 16'sh8000, 16'sh0100, 16'sh8001,
        16'sh0000, 16'sh0000, 16'sh7ffe, 16'sh0002, 16'sh0000
    };
    localparam logic signed [SAMPLE_BITS-1:0] CORNER_INFRARED [DIRECTED_COUNT] = '{
        16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
        16'sh0000, 16'sh0001, 16'shffff, 16'shffff, 16'shaaaa,
        16'sh5555, 16'sh7fff, 16'sh8000, 16'shff00, 16'sh7ffe,
        16'sh0000, 16'sh0001, 16'sh8001, 16'shfffe, 16'sh0000
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] red;
        logic signed [SAMPLE_BITS-1:0] infrared;
    } filtered_pair_t;

    typedef enum int {STALL_OFF, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

    typedef enum int {
        SEG_UNIFORM, SEG_FULL_SCALE, SEG_ALTERNATING, SEG_IMPULSE, SEG_SMALL
    } stream_shape_t;

    // Every input of the block is known from time zero.
    logic                          clk             = 1'b0;
    logic                          rst_n           = 1'b0;
    logic                          in_valid        = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] red_sample      = '0;
    logic signed [SAMPLE_BITS-1:0] infrared_sample = '0;
    logic                          out_valid;
    logic                          out_stall       = 1'b0;
    logic signed [SAMPLE_BITS-1:0] red_filtered;
    logic signed [SAMPLE_BITS-1:0] infrared_filtered;

    // Predictor state: one delay line per channel, entry k is the sample
    // taken k+1 transactions ago. Index 0 is red, index 1 is infrared.
    logic signed [SAMPLE_BITS-1:0] delay_line [2][HIST_DEPTH];

    filtered_pair_t filtered_pending[$];

    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    stall_mode_t stall_mode     = STALL_OFF;
    bit          sender_idles   = 1'b0;
    int          burst_left     = 0;
    bit          hold_request   = 1'b0;
    int          hold_left      = 0;
    bit          stalling       = 1'b0;
    int          stall_run_left = 0;

    dual_channel_fir_51tap_top #(
        .TAP_COUNT   (TAP_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .red_sample        (red_sample),
        .infrared_sample   (infrared_sample),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .red_filtered      (red_filtered),
        .infrared_filtered (infrared_filtered)
    );

    always #1 clk = ~clk;

    // Runs one sample through one channel's filter: the full-precision sum
    // over the new sample and the history, rounding to nearest with ties
    // upward (an arithmetic shift is a floor), then saturation. The delay
    // line then moves on by one.
    function automatic logic signed [SAMPLE_BITS-1:0] filter_step(
        input int                            ch,
        input logic signed [SAMPLE_BITS-1:0] x
    );
        longint acc;
        longint y;
        int     k;
        acc = longint'(LOWPASS_COEF[0]) * longint'(x);
        for (k = 1; k < TAP_COUNT; k++)
        begin
            acc += longint'(LOWPASS_COEF[k]) * longint'(delay_line[ch][k-1]);
        end
        y = (acc + ROUND_HALF) >>> FRAC_BITS;
        if (y > SAT_MAX)
        begin
            y = SAT_MAX;
        end
        if (y < SAT_MIN)
        begin
            y = SAT_MIN;
        end
        for (k = HIST_DEPTH - 1; k > 0; k--)
        begin
            delay_line[ch][k] = delay_line[ch][k-1];
        end
        delay_line[ch][0] = x;
        return y[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        logic [31:0] r;
        r = $urandom();
        return r[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_extreme();
        return ($urandom_range(0, 1) != 0) ? FULL_POS : FULL_NEG;
    endfunction

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Offers one input transaction and waits for the block to take it. Valid
    // is left high so that the next transaction of a burst follows directly;
    // once a burst is used up, an idling sender drops valid for a random gap. The
    // task is always entered at a rising edge. Stall is read straight after
    // the edge, before any update scheduled at that edge can land.
    task automatic send_pair(
        input logic signed [SAMPLE_BITS-1:0] red_val,
        input logic signed [SAMPLE_BITS-1:0] ir_val
    );
        filtered_pair_t predicted;
        in_valid        <= 1'b1;
        red_sample      <= red_val;
        infrared_sample <= ir_val;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predicted.red      = filter_step(0, red_val);
        predicted.infrared = filter_step(1, ir_val);
        filtered_pending.push_back(predicted);
        if (sender_idles)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Stops offering and waits until every predicted pair has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (filtered_pending.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Full-scale steps of both signs, single-LSB values and alternating bit
    // patterns, sent back to back with the receiver always ready.
    task automatic test_directed_corners();
        int n;
        stall_mode   = STALL_OFF;
        sender_idles = 1'b0;
        for (n = 0; n < DIRECTED_COUNT; n++)
        begin
            send_pair(CORNER_RED[n], CORNER_INFRARED[n]);
        end
        drain_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the output register and the chain head fill and the block
    // must stall its input without losing or repeating a transaction.
    task automatic test_output_backpressure();
        int n;
        stall_mode   = STALL_OFF;
        sender_idles = 1'b0;
        hold_request = 1'b1;
        for (n = 0; n < 40; n++)
        begin
            send_pair(random_sample(), random_sample());
        end
        drain_results();
    endtask

    // Streams of varied shape: uniform noise for bit coverage, held full-scale
    // levels that drive the sum to its largest magnitude, sign-alternating
    // extremes, impulses that walk through every coefficient, and small values
    // that land on rounding ties. The handshake pressure changes per stream.
    task automatic test_random_streams();
        stream_shape_t                 shape;
        int                            sent;
        int                            len;
        int                            n;
        logic signed [SAMPLE_BITS-1:0] red_level;
        logic signed [SAMPLE_BITS-1:0] ir_level;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            shape        = stream_shape_t'($urandom_range(0, 4));
            stall_mode   = stall_mode_t'($urandom_range(0, 2));
            sender_idles = ($urandom_range(0, 2) != 0);
            red_level    = random_extreme();
            ir_level     = random_extreme();
            case (shape)
                SEG_UNIFORM:
                begin
                    len = $urandom_range(10, 60);
                    for (n = 0; n < len; n++)
                    begin
                        send_pair(random_sample(), random_sample());
                    end
                end
                SEG_FULL_SCALE:
                begin
                    len = $urandom_range(TAP_COUNT, TAP_COUNT + 10);
                    for (n = 0; n < len; n++)
                    begin
                        send_pair(red_level, ir_level);
                    end
                end
                SEG_ALTERNATING:
                begin
                    len = $urandom_range(20, 60);
                    for (n = 0; n < len; n++)
                    begin
                        send_pair((n % 2 != 0) ? FULL_POS : FULL_NEG,
                                  (n % 2 != 0) ? FULL_NEG : FULL_POS);
                    end
                end
                SEG_IMPULSE:
                begin
                    len = TAP_COUNT + 1;
                    send_pair(red_level, ir_level);
                    for (n = 1; n < len; n++)
                    begin
                        send_pair('0, '0);
                    end
                end
                default:
                begin
                    len = $urandom_range(10, 40);
                    for (n = 0; n < len; n++)
                    begin
                        send_pair(SAMPLE_BITS'($urandom_range(0, 8)) - 16'sd4,
                                  SAMPLE_BITS'($urandom_range(0, 8)) - 16'sd4);
                    end
                end
            endcase
            sent += len;
        end
        drain_results();
        stall_mode = STALL_OFF;
    endtask

    // Receiver stall pattern: runs of stall and ready of random length, short
    // or long according to the mode, plus a long hold-off on request that is
    // counted here rather than by the sender.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_mode == STALL_OFF)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (stall_run_left == 0)
            begin
                stalling = !stalling;
                if (stall_mode == STALL_HEAVY)
                begin
                    stall_run_left = stalling ? $urandom_range(1, 12) : $urandom_range(1, 4);
                end
                else
                begin
                    stall_run_left = stalling ? $urandom_range(1, 4) : $urandom_range(2, 10);
                end
            end
            stall_run_left--;
            out_stall <= stalling;
        end
    end

    // Every output transaction is compared, field by field, with the oldest
    // prediction still waiting.
    always @(posedge clk)
    begin
        filtered_pair_t predicted;
        if (rst_n && out_valid && !out_stall)
        begin
            if (filtered_pending.size() == 0)
            begin
                log_mismatch($sformatf("output with none expected: red %0d infrared %0d",
                                       red_filtered, infrared_filtered));
            end
            else
            begin
                predicted = filtered_pending.pop_front();
                if (red_filtered !== predicted.red)
                begin
                    log_mismatch($sformatf("red_filtered expected %0d got %0d",
                                           predicted.red, red_filtered));
                end
                if (infrared_filtered !== predicted.infrared)
                begin
                    log_mismatch($sformatf("infrared_filtered expected %0d got %0d",
                                           predicted.infrared, infrared_filtered));
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no transaction on either side
    // means the block has hung.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int k;
        for (k = 0; k < HIST_DEPTH; k++)
        begin
            delay_line[0][k] = '0;
            delay_line[1][k] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_output_backpressure();
        test_random_streams();

        // Allow for the chain head and output register so that a stray extra output is
        // still caught by the checker.
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && filtered_pending.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/dcf_pkg.sv
hdl/dcf_tap_cell.sv
hdl/dcf_out_stage.sv
hdl/dual_channel_fir_51tap_top.sv
hdl/dcf_checker.sv
verif/dual_channel_fir_51tap_top_tb.sv
